// ===== rtl/clt_pkg.sv =====
// Shared types, constants and arithmetic helpers for the circle line tessellator.
// Used by clt_norm and circle_line_tessellator_core; depends on nothing else.
`timescale 1ns / 1ps

package clt_pkg;

   localparam int MAX_SEGMENTS_DEF = 64;
   localparam logic [6:0] MIN_SEGMENTS = 7'd3;
   localparam int CORDIC_STEPS = 16;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   // |axis_y| at or above this (0.999 in Q1.15) switches the reference axis to X.
   localparam logic signed [16:0] Y_LIMIT = 17'sd32736;
   localparam logic [15:0] TAN_DEFAULT_X = 16'h7FFF;

   typedef struct packed {
      logic [2:0][31:0] mag;
      logic [2:0]       neg;
   } norm_req_type;

   typedef struct packed {
      logic             zero;
      logic [2:0][15:0] unit;
   } norm_rsp_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } tag_type;

   // CORDIC rotation angles in units of 2^-32 turn.
   function automatic logic signed [32:0] atan_turn(input int unsigned step);
      logic signed [32:0] a;
      case (step)
         0:       a = 33'sd536870912;
         1:       a = 33'sd316933406;
         2:       a = 33'sd167458907;
         3:       a = 33'sd85004756;
         4:       a = 33'sd42667331;
         5:       a = 33'sd21354465;
         6:       a = 33'sd10679838;
         7:       a = 33'sd5340245;
         8:       a = 33'sd2670163;
         9:       a = 33'sd1335087;
         10:      a = 33'sd667544;
         11:      a = 33'sd333772;
         12:      a = 33'sd166886;
         13:      a = 33'sd83443;
         14:      a = 33'sd41722;
         15:      a = 33'sd20861;
         default: a = 33'sd0;
      endcase
      return a;
   endfunction

   // Q2.30 to Q1.15, rounded half away from zero and saturated.
   function automatic logic [15:0] round_q15(input logic signed [33:0] v);
      logic signed [34:0] t;
      logic signed [34:0] s;
      t = 35'(v) + 35'sd16384 - $signed({34'd0, v[33]});
      s = t >>> 15;
      if (s > 35'sd32767) begin
         return 16'h7FFF;
      end else if (s < -35'sd32768) begin
         return 16'h8000;
      end
      return s[15:0];
   endfunction

   function automatic logic [31:0] sat32(input logic signed [35:0] v);
      if (v > 36'sd2147483647) begin
         return 32'h7FFF_FFFF;
      end else if (v < -36'sd2147483648) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

// ===== rtl/clt_norm.sv =====
// Serial vector normalizer: scales a 3-vector to a Q1.15 unit vector.
// Shift search, squared sum, bit-serial square root and three restoring divisions.
// Depends on clt_pkg.
`timescale 1ns / 1ps

module clt_norm (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  clt_pkg::norm_req_type req,
   output logic                  done,
   output clt_pkg::norm_rsp_type rsp
);

   typedef enum logic [5:0] {
      N_IDLE  = 6'b000001,
      N_SHIFT = 6'b000010,
      N_SQ    = 6'b000100,
      N_SQRT  = 6'b001000,
      N_DIV   = 6'b010000,
      N_DONE  = 6'b100000
   } norm_state_type;

   norm_state_type   state_ff, state_in;
   logic [2:0][31:0] mag_ff, mag_in;
   logic [2:0]       neg_ff, neg_in;
   logic [63:0]      prod_ff, prod_in;
   logic [63:0]      acc_ff, acc_in;
   logic [63:0]      res_ff, res_in;
   logic [63:0]      bit_ff, bit_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [1:0]       k_ff, k_in;
   logic [33:0]      rem_ff, rem_in;
   logic [16:0]      dlo_ff, dlo_in;
   logic [16:0]      q_ff, q_in;
   logic             zero_ff, zero_in;
   logic [2:0][15:0] unit_ff, unit_in;

   logic [31:0] mag_or;
   logic [63:0] trial;
   logic [47:0] dividend;
   logic [32:0] divisor;
   logic [34:0] dstep;
   logic        ge;
   logic [31:0] mag_sel;

   assign mag_or   = mag_ff[0] | mag_ff[1] | mag_ff[2];
   assign trial    = res_ff + bit_ff;
   assign divisor  = {res_ff[31:0], 1'b0};
   assign dstep    = {rem_ff, dlo_ff[16]};
   assign ge       = dstep >= {2'b00, divisor};

   always_comb begin
      case (k_ff)
         2'd0:    mag_sel = mag_ff[0];
         2'd1:    mag_sel = mag_ff[1];
         2'd2:    mag_sel = mag_ff[2];
         default: mag_sel = '0;
      endcase
   end

   assign dividend = {mag_sel, 16'd0} + {16'd0, res_ff[31:0]};

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      bit_in   = bit_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      rem_in   = rem_ff;
      dlo_in   = dlo_ff;
      q_in     = q_ff;
      zero_in  = zero_ff;
      unit_in  = unit_ff;
      case (state_ff)
         N_IDLE, N_DONE: begin
            if (start) begin
               mag_in  = req.mag;
               neg_in  = req.neg;
               zero_in = (req.mag[0] | req.mag[1] | req.mag[2]) == '0;
               state_in = zero_in ? N_DONE : N_SHIFT;
            end
         end
         N_SHIFT: begin
            if (mag_or[31:30] == 2'b00) begin
               for (int k = 0; k < 3; k++) begin
                  mag_in[k] = {mag_ff[k][30:0], 1'b0};
               end
            end else begin
               state_in = N_SQ;
               k_in     = '0;
               cnt_in   = '0;
               acc_in   = '0;
            end
         end
         N_SQ: begin
            // Square one component per cycle; accumulate the previous one.
            if (cnt_ff != 6'd3) begin
               prod_in = mag_sel * mag_sel;
            end
            if (cnt_ff != 6'd0) begin
               acc_in = acc_ff + prod_ff;
            end
            k_in   = k_ff + 2'd1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd3) begin
               state_in = N_SQRT;
               cnt_in   = '0;
               res_in   = '0;
               bit_in   = 64'd1 << 62;
            end
         end
         N_SQRT: begin
            if (acc_ff >= trial) begin
               acc_in = acc_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               state_in = N_DIV;
               cnt_in   = '0;
               k_in     = '0;
            end
         end
         N_DIV: begin
            if (cnt_ff == 6'd0) begin
               rem_in = {3'd0, dividend[47:17]};
               dlo_in = dividend[16:0];
               q_in   = '0;
               cnt_in = 6'd1;
            end else begin
               rem_in = ge ? 34'(dstep - {2'b00, divisor}) : dstep[33:0];
               dlo_in = {dlo_ff[15:0], 1'b0};
               q_in   = {q_ff[15:0], ge};
               cnt_in = cnt_ff + 6'd1;
               if (cnt_ff == 6'd17) begin
                  // The quotient never exceeds 32768; only the positive end saturates.
                  if (neg_ff[k_ff]) begin
                     unit_in[k_ff] = 16'(-q_in);
                  end else if (q_in[16] | q_in[15]) begin
                     unit_in[k_ff] = 16'h7FFF;
                  end else begin
                     unit_in[k_ff] = q_in[15:0];
                  end
                  cnt_in = '0;
                  k_in   = k_ff + 2'd1;
                  if (k_ff == 2'd2) begin
                     state_in = N_DONE;
                  end
               end
            end
         end
         default: state_in = N_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= N_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      cnt_ff  <= cnt_in;
      k_ff    <= k_in;
      rem_ff  <= rem_in;
      dlo_ff  <= dlo_in;
      q_ff    <= q_in;
      zero_ff <= zero_in;
      unit_ff <= unit_in;
   end

   assign done = state_ff == N_DONE;
   assign rsp  = '{zero: zero_ff, unit: unit_ff};

endmodule

// ===== rtl/circle_line_tessellator_core.sv =====
// Circle line tessellator top level: frame setup sequencer and ring point pipeline.
// Depends on clt_pkg and clt_norm.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Contents
// req_      in         req_valid/req_stall  one circle: center, normal, radius, color, ...
// rsp_      out        rsp_valid/rsp_stall  one line segment per transaction
//
// A circle takes two serial normalizations (a 32-step square root and three 17-step
// divisions each), the bitangent math, then segment_count + 1 ring points (the count
// capped at MAX_SEGMENTS) issued one per cycle, while rsp_ does not stall, into the
// point pipeline. Reset is synchronous and clears control state only. A stall on
// rsp_ while rsp_valid is high freezes the whole point pipeline; req_stall stays high
// until the last segment of the current circle has been taken.

module circle_line_tessellator_core #(
   parameter int MAX_SEGMENTS = clt_pkg::MAX_SEGMENTS_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_center_x,
   input  logic [31:0] req_center_y,
   input  logic [31:0] req_center_z,
   input  logic [31:0] req_normal_x,
   input  logic [31:0] req_normal_y,
   input  logic [31:0] req_normal_z,
   input  logic [30:0] req_radius,
   input  logic [31:0] req_color_rgba,
   input  logic [30:0] req_thickness,
   input  logic [6:0]  req_segment_count,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_start_x,
   output logic [31:0] rsp_start_y,
   output logic [31:0] rsp_start_z,
   output logic [31:0] rsp_end_x,
   output logic [31:0] rsp_end_y,
   output logic [31:0] rsp_end_z,
   output logic [30:0] rsp_out_thickness,
   output logic [31:0] rsp_out_color,
   output logic        rsp_last_segment
);

   // Segment counter width and width of the phase remainder (which runs below 2n).
   localparam int SW = $clog2(MAX_SEGMENTS + 1);
   localparam int RW = SW + 1;
   localparam int NST = clt_pkg::CORDIC_STEPS;

   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_AXIS  = 7'b0000010,
      S_TAN   = 7'b0000100,
      S_BTM   = 7'b0001000,
      S_BTR   = 7'b0010000,
      S_RUN   = 7'b0100000,
      S_DRAIN = 7'b1000000
   } core_state_type;

   core_state_type state_ff, state_in;

   // Per-circle operands, held while the circle is in flight.
   logic signed [31:0] ctr_ff [3];
   logic [30:0]        rad_ff;
   logic [31:0]        color_ff;
   logic [30:0]        thick_ff;
   logic [SW-1:0]      n_ff;
   logic [SW-1:0]      n_in;
   logic signed [15:0] ax_ff [3];
   logic signed [15:0] tg_ff [3];
   logic signed [15:0] bt_ff [3];
   logic signed [31:0] pa_ff, pb_ff;
   logic [1:0]         bk_ff;

   logic accept;
   logic en;
   logic issue;

   assign accept    = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;

   // Whole point pipeline advances whenever the output register can take a new value.
   assign en    = !rsp_valid || !rsp_stall;
   assign issue = state_ff == S_RUN;

   always_comb begin
      if (req_segment_count > 7'(MAX_SEGMENTS)) begin
         n_in = SW'(MAX_SEGMENTS);
      end else begin
         n_in = SW'(req_segment_count);
      end
   end

   // ---------------------------------------------------------------------
   // Normalizer, shared between the plane axis and the tangent.
   // ---------------------------------------------------------------------
   logic                  nrm_start;
   clt_pkg::norm_req_type nrm_req;
   logic                  nrm_done;
   clt_pkg::norm_rsp_type nrm_rsp;

   clt_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (nrm_start),
      .req   (nrm_req),
      .done  (nrm_done),
      .rsp   (nrm_rsp)
   );

   // Reference cross product from the fresh unit axis: (ax_z, 0, -ax_x) for the
   // Y reference, (0, -ax_z, ax_y) for the X reference.
   logic signed [16:0] ux [3];
   logic signed [16:0] cr [3];
   logic               use_y;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ux[k] = 17'($signed(nrm_rsp.unit[k]));
      end
      use_y = (ux[1] < clt_pkg::Y_LIMIT) && (ux[1] > -clt_pkg::Y_LIMIT);
      if (use_y) begin
         cr[0] = ux[2];
         cr[1] = '0;
         cr[2] = -ux[0];
      end else begin
         cr[0] = '0;
         cr[1] = -ux[2];
         cr[2] = ux[1];
      end
   end

   always_comb begin
      nrm_start = 1'b0;
      nrm_req   = '0;
      if (state_ff == S_IDLE) begin
         nrm_start = accept && (req_segment_count >= clt_pkg::MIN_SEGMENTS);
         nrm_req.neg = {req_normal_z[31], req_normal_y[31], req_normal_x[31]};
         nrm_req.mag[0] = req_normal_x[31] ? 32'(-req_normal_x) : req_normal_x;
         nrm_req.mag[1] = req_normal_y[31] ? 32'(-req_normal_y) : req_normal_y;
         nrm_req.mag[2] = req_normal_z[31] ? 32'(-req_normal_z) : req_normal_z;
      end else begin
         nrm_start = (state_ff == S_AXIS) && nrm_done && !nrm_rsp.zero;
         for (int k = 0; k < 3; k++) begin
            nrm_req.neg[k] = cr[k][16];
            nrm_req.mag[k] = cr[k][16] ? 32'(-cr[k]) : 32'(cr[k]);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Phase step: 2^32 / n by a serial divider, run while the frame is built.
   // ---------------------------------------------------------------------
   logic [5:0]    rc_cnt_ff;
   logic [SW-1:0] rc_rem_ff;
   logic [31:0]   rc_q_ff;
   logic [RW-1:0] rc_t;
   logic          rc_ge;

   assign rc_t  = {rc_rem_ff, 1'b0};
   assign rc_ge = rc_t >= {1'b0, n_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rc_cnt_ff <= '0;
      end else if (accept) begin
         rc_cnt_ff <= 6'd32;
      end else if (rc_cnt_ff != '0) begin
         rc_cnt_ff <= rc_cnt_ff - 6'd1;
      end
      if (accept) begin
         rc_rem_ff <= SW'(1);
         rc_q_ff   <= '0;
      end else if (rc_cnt_ff != '0) begin
         rc_rem_ff <= rc_ge ? SW'(rc_t - {1'b0, n_ff}) : SW'(rc_t);
         rc_q_ff   <= {rc_q_ff[30:0], rc_ge};
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer: setup states, then one ring point per cycle while the point pipeline is not stalled.
   // ---------------------------------------------------------------------
   logic [SW-1:0]      j_ff;
   logic [31:0]        ph_ff;
   logic [RW-1:0]      pr_ff;
   logic [RW:0]        pr_sum;
   logic [RW-1:0]      two_n;
   logic               pr_wrap;
   logic signed [33:0] bt_diff;
   logic               last_taken;

   assign two_n      = {n_ff, 1'b0};
   assign pr_sum     = {1'b0, pr_ff} + {1'b0, rc_rem_ff, 1'b0};
   assign pr_wrap    = pr_sum >= {1'b0, two_n};
   assign bt_diff    = 34'(pa_ff) - 34'(pb_ff);
   assign last_taken = rsp_valid && !rsp_stall && rsp_last_segment;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && (req_segment_count >= clt_pkg::MIN_SEGMENTS)) begin
               state_in = S_AXIS;
            end
         end
         S_AXIS: begin
            if (nrm_done) begin
               state_in = nrm_rsp.zero ? S_IDLE : S_TAN;
            end
         end
         S_TAN: begin
            if (nrm_done) begin
               state_in = S_BTM;
            end
         end
         S_BTM:   state_in = S_BTR;
         S_BTR:   state_in = (bk_ff == 2'd2) ? S_RUN : S_BTM;
         S_RUN: begin
            if (en && (j_ff == n_ff)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (last_taken) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end

      if (accept) begin
         ctr_ff[0] <= req_center_x;
         ctr_ff[1] <= req_center_y;
         ctr_ff[2] <= req_center_z;
         rad_ff    <= req_radius;
         color_ff  <= req_color_rgba;
         thick_ff  <= req_thickness;
         n_ff      <= n_in;
      end

      if ((state_ff == S_AXIS) && nrm_done) begin
         for (int k = 0; k < 3; k++) begin
            ax_ff[k] <= $signed(nrm_rsp.unit[k]);
         end
      end

      // A tangent that collapses to zero falls back to the X axis.
      if ((state_ff == S_TAN) && nrm_done) begin
         bk_ff <= '0;
         if (nrm_rsp.zero) begin
            tg_ff[0] <= $signed(clt_pkg::TAN_DEFAULT_X);
            tg_ff[1] <= '0;
            tg_ff[2] <= '0;
         end else begin
            for (int k = 0; k < 3; k++) begin
               tg_ff[k] <= $signed(nrm_rsp.unit[k]);
            end
         end
      end

      // Bitangent = axis x tangent, one component per S_BTM, S_BTR state pair.
      if (state_ff == S_BTM) begin
         case (bk_ff)
            2'd0: begin
               pa_ff <= ax_ff[1] * tg_ff[2];
               pb_ff <= ax_ff[2] * tg_ff[1];
            end
            2'd1: begin
               pa_ff <= ax_ff[2] * tg_ff[0];
               pb_ff <= ax_ff[0] * tg_ff[2];
            end
            default: begin
               pa_ff <= ax_ff[0] * tg_ff[1];
               pb_ff <= ax_ff[1] * tg_ff[0];
            end
         endcase
      end
      if (state_ff == S_BTR) begin
         bt_ff[bk_ff] <= $signed(clt_pkg::round_q15(bt_diff));
         bk_ff        <= bk_ff + 2'd1;
         // Point zero has phase 0 and remainder n of the divisor 2n.
         j_ff  <= '0;
         ph_ff <= '0;
         pr_ff <= {1'b0, n_ff};
      end

      if (issue && en) begin
         j_ff  <= j_ff + SW'(1);
         ph_ff <= ph_ff + rc_q_ff + 32'(pr_wrap);
         pr_ff <= pr_wrap ? RW'(pr_sum - {1'b0, two_n}) : RW'(pr_sum);
      end
   end

   // ---------------------------------------------------------------------
   // Point pipeline: 16 CORDIC stages, quadrant fold, three multiply stages,
   // then rounding and the center offset.
   // ---------------------------------------------------------------------
   logic signed [33:0] cx_ff [0:NST];
   logic signed [33:0] cy_ff [0:NST];
   logic signed [32:0] cz_ff [0:NST];
   logic [1:0]         cq_ff [0:NST];
   clt_pkg::tag_type   ct_ff [0:NST];
   logic signed [33:0] cx_in [0:NST];
   logic signed [33:0] cy_in [0:NST];
   logic signed [32:0] cz_in [0:NST];
   logic [1:0]         cq_in [0:NST];
   clt_pkg::tag_type   ct_in [0:NST];

   always_comb begin
      cx_in[0] = clt_pkg::CORDIC_GAIN;
      cy_in[0] = '0;
      cz_in[0] = $signed({3'b000, ph_ff[29:0]});
      cq_in[0] = ph_ff[31:30];
      ct_in[0] = '{valid: issue, first: j_ff == '0, last: j_ff == n_ff};
      for (int i = 0; i < NST; i++) begin
         if (!cz_ff[i][32]) begin
            cx_in[i+1] = cx_ff[i] - (cy_ff[i] >>> i);
            cy_in[i+1] = cy_ff[i] + (cx_ff[i] >>> i);
            cz_in[i+1] = cz_ff[i] - clt_pkg::atan_turn(i);
         end else begin
            cx_in[i+1] = cx_ff[i] + (cy_ff[i] >>> i);
            cy_in[i+1] = cy_ff[i] - (cx_ff[i] >>> i);
            cz_in[i+1] = cz_ff[i] + clt_pkg::atan_turn(i);
         end
         cq_in[i+1] = cq_ff[i];
         ct_in[i+1] = ct_ff[i];
      end
   end

   // Quadrant fold of the final CORDIC vector.
   logic signed [33:0] xq, yq;

   always_comb begin
      case (cq_ff[NST])
         QUAD_1: begin
            xq = -cy_ff[NST];
            yq = cx_ff[NST];
         end
         QUAD_2: begin
            xq = -cx_ff[NST];
            yq = -cy_ff[NST];
         end
         QUAD_3: begin
            xq = cy_ff[NST];
            yq = -cx_ff[NST];
         end
         default: begin
            xq = cx_ff[NST];
            yq = cy_ff[NST];
         end
      endcase
   end

   logic signed [15:0] cos_ff, sin_ff;
   clt_pkg::tag_type   rt_ff;
   logic signed [31:0] mt_ff [3];
   logic signed [31:0] ms_ff [3];
   clt_pkg::tag_type   m1t_ff;
   logic signed [32:0] dir_ff [3];
   clt_pkg::tag_type   m2t_ff;
   logic signed [63:0] off_ff [3];
   clt_pkg::tag_type   m3t_ff;
   logic signed [31:0] pt_ff [3];
   clt_pkg::tag_type   pt_tag_ff;

   logic signed [64:0] off_full [3];
   logic signed [63:0] off_rnd [3];
   logic signed [35:0] pos_sum [3];
   logic [31:0]        pos_sat [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         off_full[k] = $signed({1'b0, rad_ff}) * dir_ff[k];
         // Round half away from zero from Q18.46 to Q16.16.
         off_rnd[k]  = (off_ff[k] + 64'sd536870912 - $signed({63'd0, off_ff[k][63]})) >>> 30;
         pos_sum[k]  = $signed(off_rnd[k][35:0]) + 36'(ctr_ff[k]);
         pos_sat[k]  = clt_pkg::sat32(pos_sum[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= NST; i++) begin
            ct_ff[i] <= '0;
         end
         rt_ff     <= '0;
         m1t_ff    <= '0;
         m2t_ff    <= '0;
         m3t_ff    <= '0;
         pt_tag_ff <= '0;
      end else if (en) begin
         for (int i = 0; i <= NST; i++) begin
            ct_ff[i] <= ct_in[i];
         end
         rt_ff     <= ct_ff[NST];
         m1t_ff    <= rt_ff;
         m2t_ff    <= m1t_ff;
         m3t_ff    <= m2t_ff;
         pt_tag_ff <= m3t_ff;
      end
      if (en) begin
         for (int i = 0; i <= NST; i++) begin
            cx_ff[i] <= cx_in[i];
            cy_ff[i] <= cy_in[i];
            cz_ff[i] <= cz_in[i];
            cq_ff[i] <= cq_in[i];
         end
         cos_ff <= $signed(clt_pkg::round_q15(xq));
         sin_ff <= $signed(clt_pkg::round_q15(yq));
         for (int k = 0; k < 3; k++) begin
            mt_ff[k]  <= tg_ff[k] * cos_ff;
            ms_ff[k]  <= bt_ff[k] * sin_ff;
            dir_ff[k] <= 33'(mt_ff[k]) + 33'(ms_ff[k]);
            off_ff[k] <= off_full[k][63:0];
            pt_ff[k]  <= $signed(pos_sat[k]);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Output register: each point past the first closes a segment that starts
   // at the previous point.
   // ---------------------------------------------------------------------
   logic signed [31:0] prev_ff [3];
   logic               rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= pt_tag_ff.valid && !pt_tag_ff.first;
      end
      if (en && pt_tag_ff.valid) begin
         for (int k = 0; k < 3; k++) begin
            prev_ff[k] <= pt_ff[k];
         end
         rsp_start_x       <= prev_ff[0];
         rsp_start_y       <= prev_ff[1];
         rsp_start_z       <= prev_ff[2];
         rsp_end_x         <= pt_ff[0];
         rsp_end_y         <= pt_ff[1];
         rsp_end_z         <= pt_ff[2];
         rsp_out_thickness <= thick_ff;
         rsp_out_color     <= color_ff;
         rsp_last_segment  <= pt_tag_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== bench/circle_line_tessellator_checker.sv =====
// Segment checker for the circle line tessellator: watches both channels, predicts
// every line segment of each accepted circle and compares. Depends on nothing else.
`timescale 1ns / 1ps

module circle_line_tessellator_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_center_x,
   input  logic [31:0] req_center_y,
   input  logic [31:0] req_center_z,
   input  logic [31:0] req_normal_x,
   input  logic [31:0] req_normal_y,
   input  logic [31:0] req_normal_z,
   input  logic [30:0] req_radius,
   input  logic [31:0] req_color_rgba,
   input  logic [30:0] req_thickness,
   input  logic [6:0]  req_segment_count,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_start_x,
   input  logic [31:0] rsp_start_y,
   input  logic [31:0] rsp_start_z,
   input  logic [31:0] rsp_end_x,
   input  logic [31:0] rsp_end_y,
   input  logic [31:0] rsp_end_z,
   input  logic [30:0] rsp_out_thickness,
   input  logic [31:0] rsp_out_color,
   input  logic        rsp_last_segment,
   output int          mismatch_count,
   output int          segments_pending
);

   localparam int SEG_LIMIT = 64;
   localparam longint Y_SWITCH = 32736;
   localparam longint ROT_GAIN = 652032874;

   typedef struct {
      logic [31:0] start_x, start_y, start_z, end_x, end_y, end_z;
      logic [30:0] thickness;
      logic [31:0] color;
      logic        last;
   } segment_type;

   segment_type expected_segments[$];

   function automatic longint rot_angle(input int k);
      longint tab [16] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                           10679838, 5340245, 2670163, 1335087, 667544, 333772,
                           166886, 83443, 41722, 20861};
      return tab[k];
   endfunction

   function automatic longint round_shift(input longint v, input int s);
      longint half;
      half = longint'(1) << (s - 1);
      if (v >= 0) return (v + half) >>> s;
      return -(((-v) + half) >>> s);
   endfunction

   function automatic longint clamp_q15(input longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned s);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
         if (s >= res + b) begin
            s -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // Scales the vector up to full range first so the square root keeps precision.
   function automatic bit unit_vector(input longint vin [3], output longint vout [3]);
      longint v [3];
      longint unsigned m, sum, len, a, q;
      m = 0;
      sum = 0;
      for (int k = 0; k < 3; k++) begin
         v[k] = vin[k];
         a = v[k] < 0 ? -v[k] : v[k];
         if (a > m) m = a;
      end
      if (m == 0) return 0;
      while (m < (64'd1 << 30)) begin
         m *= 2;
         for (int k = 0; k < 3; k++) v[k] *= 2;
      end
      for (int k = 0; k < 3; k++) begin
         a = v[k] < 0 ? -v[k] : v[k];
         sum += a * a;
      end
      len = int_sqrt(sum);
      for (int k = 0; k < 3; k++) begin
         a = v[k] < 0 ? -v[k] : v[k];
         q = (a * 65536 + len) / (2 * len);
         vout[k] = clamp_q15(v[k] < 0 ? -longint'(q) : longint'(q));
      end
      return 1;
   endfunction

   function automatic void sin_cos(input logic [31:0] phase, output longint c,
                                   output longint s);
      longint x, y, z, t, dx, dy;
      x = ROT_GAIN;
      y = 0;
      z = longint'(phase[29:0]);
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= rot_angle(i);
         end else begin
            x += dx; y -= dy; z += rot_angle(i);
         end
      end
      case (phase[31:30])
         2'd1: begin t = x; x = -y; y = t; end
         2'd2: begin x = -x; y = -y; end
         2'd3: begin t = x; x = y; y = -t; end
         default: ;
      endcase
      c = clamp_q15(round_shift(x, 15));
      s = clamp_q15(round_shift(y, 15));
   endfunction

   function automatic void ring_point(input longint ctr [3], input longint tg [3],
                                      input longint bt [3], input longint rad,
                                      input logic [31:0] phase, output longint p [3]);
      longint c, s, dir;
      sin_cos(phase, c, s);
      for (int k = 0; k < 3; k++) begin
         dir = tg[k] * c + bt[k] * s;
         p[k] = clamp32(ctr[k] + round_shift(rad * dir, 30));
      end
   endfunction

   task automatic predict_circle();
      longint ctr [3], nrm [3], ax [3], cr [3], tg [3], bt [3], prev [3], cur [3];
      longint rad, ay;
      longint unsigned ph;
      int n;
      segment_type seg;
      n = req_segment_count;
      if (n < 3) return;
      if (n > SEG_LIMIT) n = SEG_LIMIT;
      ctr[0] = longint'($signed(req_center_x));
      ctr[1] = longint'($signed(req_center_y));
      ctr[2] = longint'($signed(req_center_z));
      nrm[0] = longint'($signed(req_normal_x));
      nrm[1] = longint'($signed(req_normal_y));
      nrm[2] = longint'($signed(req_normal_z));
      rad = longint'(req_radius);
      if (!unit_vector(nrm, ax)) return;
      ay = ax[1] < 0 ? -ax[1] : ax[1];
      if (ay < Y_SWITCH) begin
         cr[0] = ax[2]; cr[1] = 0; cr[2] = -ax[0];
      end else begin
         cr[0] = 0; cr[1] = -ax[2]; cr[2] = ax[1];
      end
      if (!unit_vector(cr, tg)) begin
         tg[0] = 32767; tg[1] = 0; tg[2] = 0;
      end
      bt[0] = clamp_q15(round_shift(ax[1] * tg[2] - ax[2] * tg[1], 15));
      bt[1] = clamp_q15(round_shift(ax[2] * tg[0] - ax[0] * tg[2], 15));
      bt[2] = clamp_q15(round_shift(ax[0] * tg[1] - ax[1] * tg[0], 15));
      ring_point(ctr, tg, bt, rad, 32'd0, prev);
      for (int i = 1; i <= n; i++) begin
         ph = ((longint'(i) << 33) + n) / (2 * n);
         ring_point(ctr, tg, bt, rad, ph[31:0], cur);
         seg.start_x = prev[0][31:0];
         seg.start_y = prev[1][31:0];
         seg.start_z = prev[2][31:0];
         seg.end_x = cur[0][31:0];
         seg.end_y = cur[1][31:0];
         seg.end_z = cur[2][31:0];
         seg.thickness = req_thickness;
         seg.color = req_color_rgba;
         seg.last = (i == n);
         expected_segments.insert(expected_segments.size(), seg);
         prev = cur;
      end
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      segment_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_segments.size() == 0) begin
               report_mismatch("unexpected segment", rsp_start_x, 32'd0);
            end else begin
               want = expected_segments.pop_front();
               if (rsp_start_x !== want.start_x)
                  report_mismatch("start_x", rsp_start_x, want.start_x);
               if (rsp_start_y !== want.start_y)
                  report_mismatch("start_y", rsp_start_y, want.start_y);
               if (rsp_start_z !== want.start_z)
                  report_mismatch("start_z", rsp_start_z, want.start_z);
               if (rsp_end_x !== want.end_x) report_mismatch("end_x", rsp_end_x, want.end_x);
               if (rsp_end_y !== want.end_y) report_mismatch("end_y", rsp_end_y, want.end_y);
               if (rsp_end_z !== want.end_z) report_mismatch("end_z", rsp_end_z, want.end_z);
               if (rsp_out_thickness !== want.thickness)
                  report_mismatch("out_thickness", 32'(rsp_out_thickness),
                                  32'(want.thickness));
               if (rsp_out_color !== want.color)
                  report_mismatch("out_color", rsp_out_color, want.color);
               if (rsp_last_segment !== want.last)
                  report_mismatch("last_segment", 32'(rsp_last_segment), 32'(want.last));
            end
         end
         if (req_valid && !req_stall) predict_circle();
      end
      segments_pending = expected_segments.size();
   end

endmodule

// ===== bench/circle_line_tessellator_core_tb.sv =====
// Testbench top for circle_line_tessellator_core: drives circles with random gaps,
// stalls the segment channel and gives the verdict. Depends on the core and the checker module.
`timescale 1ns / 1ps

module circle_line_tessellator_core_tb;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_center_x, req_center_y, req_center_z;
   logic [31:0] req_normal_x, req_normal_y, req_normal_z;
   logic [30:0] req_radius;
   logic [31:0] req_color_rgba;
   logic [30:0] req_thickness;
   logic [6:0]  req_segment_count;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_start_x, rsp_start_y, rsp_start_z;
   logic [31:0] rsp_end_x, rsp_end_y, rsp_end_z;
   logic [30:0] rsp_out_thickness;
   logic [31:0] rsp_out_color;
   logic        rsp_last_segment;
   int          mismatch_count;
   int          segments_pending;
   int          segments_taken;
   // When set, the receiver takes segments back to back.
   bit          eager_receiver;

   circle_line_tessellator_core i_dut (.*);

   circle_line_tessellator_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The run must end long before this even with every circle at full length.
   initial begin
      #20ms;
      $display("end of test: mismatches");
      $finish;
   end

   // Sends one circle transaction after a random gap and waits for its acceptance.
   // The task starts and ends at a falling edge, so valid is only assigned once
   // per time step even when two circles follow back to back.
   task automatic send_circle(input logic [31:0] cx, cy, cz, nx, ny, nz,
                              input logic [30:0] rad, input logic [31:0] color,
                              input logic [30:0] thick, input logic [6:0] count);
      int gap;
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_center_x <= cx;
      req_center_y <= cy;
      req_center_z <= cz;
      req_normal_x <= nx;
      req_normal_y <= ny;
      req_normal_z <= nz;
      req_radius <= rad;
      req_color_rgba <= color;
      req_thickness <= thick;
      req_segment_count <= count;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Normals are mostly of moderate size, with some at full range and some
   // nearly along Y so that the reference axis switches to X.
   function automatic logic [31:0] pick_normal();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 200000)) - 100000);
         2: return 32'($signed($urandom_range(0, 20)) - 10);
         default: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
      endcase
   endfunction

   function automatic logic [31:0] pick_center();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
   endfunction

   function automatic logic [6:0] pick_count();
      case ($urandom_range(0, 9))
         0: return 7'($urandom_range(0, 2));
         1: return 7'($urandom_range(3, 64));
         2: return 7'($urandom_range(65, 127));
         default: return 7'($urandom_range(3, 12));
      endcase
   endfunction

   // Segment receiver: a random hold-off before each segment, with stretches
   // of none, and one long hold-off early on so the point pipeline fills and
   // req_stall is seen while the sender keeps offering circles.
   initial begin
      int holdoff;
      rsp_stall = 1'b1;
      segments_taken = 0;
      eager_receiver = 1'b0;
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 40) == 0) eager_receiver = ~eager_receiver;
         holdoff = eager_receiver ? 0 : $urandom_range(0, 12);
         if (segments_taken == 20) holdoff = 400;
         if (holdoff > 0) begin
            rsp_stall <= 1'b1;
            repeat (holdoff) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         segments_taken++;
         @(negedge clock);
      end
   end

   initial begin
      int drain_cycles;
      reset = 1'b1;
      req_valid = 1'b0;
      req_center_x = '0;
      req_center_y = '0;
      req_center_z = '0;
      req_normal_x = '0;
      req_normal_y = '0;
      req_normal_z = '0;
      req_radius = '0;
      req_color_rgba = '0;
      req_thickness = '0;
      req_segment_count = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed circles: short counts, the smallest and largest ring, counts
      // past the segment limit, a zero normal, normals along each axis and at
      // full range, and extreme centers and radii that drive saturation.
      send_circle(0, 0, 0, 0, 32'h0001_0000, 0, 31'h0001_0000, 32'hFF00_00FF, 31'd1, 7'd0);
      send_circle(0, 0, 0, 0, 0, 32'h0001_0000, 31'h0001_0000, 32'h1234_5678, 31'd2, 7'd1);
      send_circle(0, 0, 0, 32'h0001_0000, 0, 0, 31'h0001_0000, 32'h0, 31'd3, 7'd2);
      send_circle(0, 0, 0, 0, 0, 32'h0001_0000, 31'h0001_0000, 32'hFFFF_FFFF,
                  31'h7FFF_FFFF, 7'd3);
      send_circle(0, 0, 0, 0, 0, 0, 31'h0001_0000, 32'hAAAA_5555, 31'd5, 7'd8);
      send_circle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h0001_0000, 0,
                  31'h7FFF_FFFF, 32'h5555_AAAA, 31'h5555_5555, 7'd64);
      send_circle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_0000, 0,
                  31'h7FFF_FFFF, 32'h0F0F_F0F0, 31'h2AAA_AAAA, 7'd65);
      send_circle(32'h0010_0000, 32'hFFF0_0000, 0, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 31'h0003_0000, 32'h0102_0304, 31'd0, 7'd127);
      send_circle(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h0,
                  32'h8080_8080, 31'd7, 7'd5);
      send_circle(0, 0, 0, 32'h0000_0001, 0, 0, 31'h0002_0000, 32'h0, 31'd8, 7'd4);
      send_circle(0, 0, 0, 0, 32'h0000_0001, 32'h0000_0001, 31'h0002_0000, 32'h0,
                  31'd9, 7'd6);
      send_circle(0, 0, 0, 32'h0000_0001, 32'h0000_03E8, 0, 31'h0001_0000, 32'h0,
                  31'd10, 7'd7);
      send_circle(0, 0, 0, 0, 32'h8000_0000, 0, 31'h0004_0000, 32'h0, 31'd11, 7'd3);
      send_circle(32'h1234_5678, 32'hEDCB_A987, 32'h0BAD_F00D, 32'hFFFF_FFFF,
                  32'h0000_0002, 32'hFFFF_FFFD, 31'h0000_8000, 32'hDEAD_BEEF,
                  31'd12, 7'd10);

      // Random circles: mostly valid counts with random geometry.
      repeat (250) begin
         logic [30:0] rad;
         rad = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                           : 31'($urandom_range(0, 1 << 22));
         send_circle(pick_center(), pick_center(), pick_center(),
                     pick_normal(), pick_normal(), pick_normal(), rad,
                     $urandom, 31'($urandom), pick_count());
      end
      req_valid <= 1'b0;

      // A circle with no segments may still be in setup when the queue is empty,
      // so keep watching for a while after it drains.
      while (segments_pending != 0) @(posedge clock);
      drain_cycles = 0;
      while (drain_cycles < 2000) begin
         @(posedge clock);
         drain_cycles++;
      end
      if (mismatch_count == 0 && segments_pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/clt_pkg.sv
rtl/clt_norm.sv
rtl/circle_line_tessellator_core.sv
bench/circle_line_tessellator_checker.sv
bench/circle_line_tessellator_core_tb.sv
